@@ rtl/ltf_pkg.sv @@
// ltf_pkg: widths, state encoding and shared types for the touch calibration line fit
// no dependencies; every other rtl file except ltf_ram refers to it by scoped names

package ltf_pkg;

    // sample storage
    localparam int MAX_SAMPLES = 16;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);

    // field widths
    localparam int SCR_W   = 10;
    localparam int RAW_W   = 16;
    localparam int CFG_W   = 13;
    localparam int ENTRY_W = 2 * SCR_W + 2 * RAW_W;
    localparam int OUT_W   = 17;
    localparam int ERR_W   = 16;

    // stream widths
    localparam int S_TDATA_W = ((ENTRY_W + 7) / 8) * 8;
    localparam int M_FIELD_W = 4 * OUT_W + 4 * ERR_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // running sums
    localparam int S_W  = SCR_W + ADDR_W;
    localparam int R_W  = RAW_W + ADDR_W;
    localparam int SS_W = 2 * SCR_W + ADDR_W;
    localparam int SR_W = SCR_W + RAW_W + ADDR_W;

    // fit arithmetic
    localparam int MA_W    = 40;
    localparam int MB_W    = 16;
    localparam int P_W     = MA_W + MB_W;
    localparam int WIDE_W  = 58;
    localparam int DEN_W   = SS_W + CNT_W + 1;
    localparam int NUM_W   = SR_W + CNT_W + 1;
    localparam int SLOPE_W = 38;
    localparam int DIVD_W  = 64;
    localparam int DIVR_W  = 40;
    localparam int DCNT_W  = $clog2(DIVD_W);
    localparam int RES_W   = 32;
    localparam int TOT_W   = RES_W + ADDR_W;
    localparam int FRAC_SH = 12;

    localparam logic [DIVD_W-1:0] SLOPE_LIM  = DIVD_W'(64'd1 << 36);
    localparam logic [DIVD_W-1:0] EP_POS_MAX = DIVD_W'(65535);
    localparam logic [DIVD_W-1:0] EP_NEG_MAX = DIVD_W'(65536);
    localparam logic [DIVD_W-1:0] RES_MAX    = DIVD_W'(32'hFFFF_FFFF);

    // configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]     PANEL_WIDTH_RST  = 13'd320;
    localparam logic [CFG_W-1:0]     PANEL_HEIGHT_RST = 13'd480;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD0, ST_LD1, ST_LD2, ST_LD3, ST_LD4,
        ST_CHK, ST_M1, ST_M2, ST_M3, ST_M4,
        ST_SLOPE, ST_SLOPE_W,
        ST_IC0, ST_IC1, ST_IC_W,
        ST_E0, ST_E1,
        ST_RD, ST_RM, ST_RDIV, ST_R_W,
        ST_MEAN, ST_MEAN_W,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

endpackage

@@ rtl/ltf_ram.sv @@
// ltf_ram: generic single write port, single read port ram with registered read
// no dependencies

module ltf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/ltf_mul.sv @@
// ltf_mul: shared signed by unsigned multiplier with registered product
// depends on ltf_pkg

module ltf_mul (
    input  logic                               clk,
    input  logic signed [ltf_pkg::MA_W-1:0]    a,
    input  logic        [ltf_pkg::MB_W-1:0]    b,
    output logic signed [ltf_pkg::P_W-1:0]     p_reg
);

    logic signed [ltf_pkg::P_W:0] prod;

    assign prod = a * $signed({1'b0, b});

    always_ff @(posedge clk)
    begin
        p_reg <= prod[ltf_pkg::P_W-1:0];
    end

endmodule

@@ rtl/ltf_div.sv @@
// ltf_div: iterative restoring divider, one quotient bit a cycle, rounds half up
// depends on ltf_pkg (div_req_t and widths)

module ltf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ltf_pkg::div_req_t             req,
    output logic                          done_reg,
    output logic [ltf_pkg::DIVD_W-1:0]    quo_reg
);

    logic                          busy_reg;
    logic [ltf_pkg::DCNT_W-1:0]    cnt_reg;
    logic [ltf_pkg::DIVD_W-1:0]    num_reg;
    logic [ltf_pkg::DIVR_W-1:0]    den_reg;
    logic [ltf_pkg::DIVR_W:0]      rem_reg;
    logic [ltf_pkg::DIVR_W:0]      rem_sh;
    logic                          fits;

    assign rem_sh = {rem_reg[ltf_pkg::DIVR_W-1:0], num_reg[ltf_pkg::DIVD_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // rounding: the half divisor is folded into the dividend
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend + ltf_pkg::DIVD_W'(req.divisor >> 1);
            den_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[ltf_pkg::DIVD_W-2:0], fits};
            rem_reg <= fits ? rem_sh - {1'b0, den_reg} : rem_sh;
        end
    end

endmodule

@@ rtl/touch_calibration_line_fit.sv @@
// touch_calibration_line_fit: top level, sample loader, fit sequencer and result register
// depends on ltf_pkg, ltf_ram, ltf_mul, ltf_div

// Collects calibration samples (screen point plus averaged 12.4 raw reading) and, on the
// transaction marked tlast, fits raw = slope*screen + intercept per axis by least squares.
// Each sample is accepted in the idle state and then passes through the load states LD0 to
// LD4, in which the shared multiplier forms the squared and cross products for the running
// sums; s_tready is low meanwhile. Samples beyond sixteen are dropped, but their tlast
// still starts the fit. The fit reuses that multiplier and one 64-step restoring divider:
// per axis three divisions (slope, intercept, mean residual) plus one per stored sample,
// while the endpoints are a rounding shift. A fit that fails (fewer than two samples,
// singular sums or zero slope) finishes early. The result sits in an output register, so a
// new batch can be loaded while it waits; a second result waits for the first to be taken.
// Panel size registers are written through cfg_we; the user must do so only while the
// block is idle, which the block itself does not enforce.

module touch_calibration_line_fit (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave side
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // screen_x, screen_y, raw_x, raw_y, zero pad
    input  logic [ltf_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    // master side
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // x_at_left, x_at_right, y_at_top, y_at_bottom, x_error_mean, x_error_max,
    // y_error_mean, y_error_max, zero pad
    output logic [ltf_pkg::M_TDATA_W-1:0]     m_tdata,
    // fit_failed
    output logic                              m_tuser,
    // configuration
    input  logic                              cfg_we,
    input  logic [ltf_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [ltf_pkg::CFG_W-1:0]         cfg_wdata
);

    ltf_pkg::state_t state_reg, state_next;

    // panel size registers
    logic [ltf_pkg::CFG_W-1:0] pw_reg, ph_reg;

    // batch state
    logic [ltf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [ltf_pkg::S_W-1:0]   s_sum_reg  [2];
    logic [ltf_pkg::S_W-1:0]   s_sum_next [2];
    logic [ltf_pkg::R_W-1:0]   r_sum_reg  [2];
    logic [ltf_pkg::R_W-1:0]   r_sum_next [2];
    logic [ltf_pkg::SS_W-1:0]  ss_sum_reg [2];
    logic [ltf_pkg::SS_W-1:0]  ss_sum_next[2];
    logic [ltf_pkg::SR_W-1:0]  sr_sum_reg [2];
    logic [ltf_pkg::SR_W-1:0]  sr_sum_next[2];

    // latched sample
    logic [ltf_pkg::SCR_W-1:0] sx_reg, sy_reg;
    logic [ltf_pkg::RAW_W-1:0] rx_reg, ry_reg;
    logic                      last_reg, keep_reg;

    // fit datapath
    logic                               ax_reg, ax_next;
    logic                               fail_reg, fail_next;
    logic                               tneg_reg, tneg_next;
    logic signed [ltf_pkg::P_W-1:0]     acc_reg, acc_next;
    logic signed [ltf_pkg::DEN_W-1:0]   den_reg, den_next;
    logic signed [ltf_pkg::NUM_W-1:0]   num_reg, num_next;
    logic signed [ltf_pkg::SLOPE_W-1:0] slope_reg, slope_next;
    logic signed [ltf_pkg::WIDE_W-1:0]  icpt_reg, icpt_next;
    logic [ltf_pkg::CNT_W-1:0]          idx_reg, idx_next;
    logic [ltf_pkg::RAW_W-1:0]          r_reg, r_next;
    logic [ltf_pkg::TOT_W-1:0]          total_reg, total_next;
    logic [ltf_pkg::RES_W-1:0]          worst_reg, worst_next;

    // per-axis results
    logic [ltf_pkg::OUT_W-1:0] lo_reg  [2];
    logic [ltf_pkg::OUT_W-1:0] lo_next [2];
    logic [ltf_pkg::OUT_W-1:0] hi_reg  [2];
    logic [ltf_pkg::OUT_W-1:0] hi_next [2];
    logic [ltf_pkg::ERR_W-1:0] mean_reg [2];
    logic [ltf_pkg::ERR_W-1:0] mean_next[2];
    logic [ltf_pkg::ERR_W-1:0] max_reg  [2];
    logic [ltf_pkg::ERR_W-1:0] max_next [2];

    // output register
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [ltf_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg, m_tuser_next;

    // shared units
    logic signed [ltf_pkg::MA_W-1:0] mul_a;
    logic [ltf_pkg::MB_W-1:0]        mul_b;
    logic signed [ltf_pkg::P_W-1:0]  p_reg;
    ltf_pkg::div_req_t               div_req;
    logic                            div_done;
    logic [ltf_pkg::DIVD_W-1:0]      div_q;

    // sample store
    logic [ltf_pkg::ENTRY_W-1:0] ram_rdata;
    logic                        ram_we;

    logic                              s_acc;
    logic                              fail_now;
    logic                              out_free;
    logic                              last_idx;
    logic [ltf_pkg::S_W-1:0]           s_sel;
    logic [ltf_pkg::R_W-1:0]           r_sel;
    logic [ltf_pkg::SS_W-1:0]          ss_sel;
    logic [ltf_pkg::SR_W-1:0]          sr_sel;
    logic [ltf_pkg::CFG_W-1:0]         size_sel;
    logic [ltf_pkg::CFG_W-1:0]         span;
    logic [ltf_pkg::SCR_W-1:0]         st_s;
    logic [ltf_pkg::RAW_W-1:0]         st_r;
    logic signed [ltf_pkg::WIDE_W-1:0] t_w;
    logic [ltf_pkg::WIDE_W-1:0]        t_mag;
    logic [ltf_pkg::WIDE_W-1:0]        ep_q;
    logic [ltf_pkg::SLOPE_W-1:0]       slope_mag;
    logic [ltf_pkg::SLOPE_W-1:0]       aslope;
    logic [ltf_pkg::RES_W-1:0]         res;

    // endpoint: sign and magnitude to 17-bit two's complement, saturated
    function automatic logic [ltf_pkg::OUT_W-1:0] sat_ep(input logic neg,
                                                         input logic [ltf_pkg::DIVD_W-1:0] q);
        logic [ltf_pkg::OUT_W-1:0] m;
        m = ltf_pkg::OUT_W'(q);
        if (neg)
        begin
            return (q > ltf_pkg::EP_NEG_MAX) ? ltf_pkg::OUT_W'(ltf_pkg::EP_NEG_MAX) : -m;
        end
        return (q > ltf_pkg::EP_POS_MAX) ? ltf_pkg::OUT_W'(ltf_pkg::EP_POS_MAX) : m;
    endfunction

    function automatic logic [ltf_pkg::ERR_W-1:0] sat_err(input logic [ltf_pkg::DIVD_W-1:0] q);
        return (q > ltf_pkg::DIVD_W'({ltf_pkg::ERR_W{1'b1}})) ? '1 : ltf_pkg::ERR_W'(q);
    endfunction

    assign s_tready = (state_reg == ltf_pkg::ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign ram_we   = s_acc && (cnt_reg < ltf_pkg::CNT_W'(ltf_pkg::MAX_SAMPLES));

    // axis selection
    assign s_sel    = s_sum_reg[ax_reg];
    assign r_sel    = r_sum_reg[ax_reg];
    assign ss_sel   = ss_sum_reg[ax_reg];
    assign sr_sel   = sr_sum_reg[ax_reg];
    assign size_sel = ax_reg ? ph_reg : pw_reg;
    assign span     = (size_sel == '0) ? '0 : size_sel - 1'b1;
    assign st_s     = ax_reg ? ram_rdata[2*ltf_pkg::SCR_W-1 -: ltf_pkg::SCR_W]
                             : ram_rdata[ltf_pkg::SCR_W-1:0];
    assign st_r     = ax_reg ? ram_rdata[ltf_pkg::ENTRY_W-1 -: ltf_pkg::RAW_W]
                             : ram_rdata[2*ltf_pkg::SCR_W+ltf_pkg::RAW_W-1 -: ltf_pkg::RAW_W];
    assign aslope   = (slope_reg < 0) ? ltf_pkg::SLOPE_W'(-slope_reg)
                                      : ltf_pkg::SLOPE_W'(slope_reg);
    assign last_idx = (idx_reg + 1'b1) == cnt_reg;

    // fit failure: too few samples, singular sums, zero slope
    always_comb
    begin
        unique case (state_reg)
            ltf_pkg::ST_CHK: fail_now = cnt_reg < ltf_pkg::CNT_W'(2);
            ltf_pkg::ST_M4:  fail_now = den_reg <= 0;
            ltf_pkg::ST_IC0: fail_now = slope_reg == 0;
            default:         fail_now = 1'b0;
        endcase
    end

    // the one wide signed term of the slope, intercept and residual divisions and of the endpoints, then its magnitude
    always_comb
    begin
        unique case (state_reg)
            ltf_pkg::ST_SLOPE: t_w = ltf_pkg::WIDE_W'(num_reg) <<< ltf_pkg::FRAC_SH;
            ltf_pkg::ST_IC1:   t_w = $signed(ltf_pkg::WIDE_W'({r_sel, 12'b0}))
                                     - ltf_pkg::WIDE_W'(p_reg);
            ltf_pkg::ST_E0:    t_w = icpt_reg;
            ltf_pkg::ST_E1:    t_w = icpt_reg + ltf_pkg::WIDE_W'(p_reg);
            ltf_pkg::ST_RDIV:  t_w = $signed(ltf_pkg::WIDE_W'({r_reg, 12'b0})) - icpt_reg
                                     - ltf_pkg::WIDE_W'(p_reg);
            default:           t_w = '0;
        endcase
    end
    assign t_mag = (t_w < 0) ? ltf_pkg::WIDE_W'(-t_w) : ltf_pkg::WIDE_W'(t_w);

    // endpoints drop the 12 fraction bits, rounding half away from zero
    assign ep_q = (t_mag + (ltf_pkg::WIDE_W'(1) << (ltf_pkg::FRAC_SH - 1))) >> ltf_pkg::FRAC_SH;

    assign slope_mag = (div_q > ltf_pkg::SLOPE_LIM) ? ltf_pkg::SLOPE_W'(ltf_pkg::SLOPE_LIM)
                                                   : ltf_pkg::SLOPE_W'(div_q);
    assign res       = (div_q > ltf_pkg::RES_MAX) ? '1 : ltf_pkg::RES_W'(div_q);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ltf_pkg::ST_IDLE:    if (s_acc) state_next = ltf_pkg::ST_LD0;
            ltf_pkg::ST_LD0:     state_next = ltf_pkg::ST_LD1;
            ltf_pkg::ST_LD1:     state_next = ltf_pkg::ST_LD2;
            ltf_pkg::ST_LD2:     state_next = ltf_pkg::ST_LD3;
            ltf_pkg::ST_LD3:     state_next = ltf_pkg::ST_LD4;
            ltf_pkg::ST_LD4:     state_next = last_reg ? ltf_pkg::ST_CHK : ltf_pkg::ST_IDLE;
            ltf_pkg::ST_CHK:     state_next = fail_now ? ltf_pkg::ST_DONE : ltf_pkg::ST_M1;
            ltf_pkg::ST_M1:      state_next = ltf_pkg::ST_M2;
            ltf_pkg::ST_M2:      state_next = ltf_pkg::ST_M3;
            ltf_pkg::ST_M3:      state_next = ltf_pkg::ST_M4;
            ltf_pkg::ST_M4:      state_next = fail_now ? ltf_pkg::ST_DONE : ltf_pkg::ST_SLOPE;
            ltf_pkg::ST_SLOPE:   state_next = ltf_pkg::ST_SLOPE_W;
            ltf_pkg::ST_SLOPE_W: if (div_done) state_next = ltf_pkg::ST_IC0;
            ltf_pkg::ST_IC0:     state_next = fail_now ? ltf_pkg::ST_DONE : ltf_pkg::ST_IC1;
            ltf_pkg::ST_IC1:     state_next = ltf_pkg::ST_IC_W;
            ltf_pkg::ST_IC_W:    if (div_done) state_next = ltf_pkg::ST_E0;
            ltf_pkg::ST_E0:      state_next = ltf_pkg::ST_E1;
            ltf_pkg::ST_E1:      state_next = ltf_pkg::ST_RD;
            ltf_pkg::ST_RD:      state_next = ltf_pkg::ST_RM;
            ltf_pkg::ST_RM:      state_next = ltf_pkg::ST_RDIV;
            ltf_pkg::ST_RDIV:    state_next = ltf_pkg::ST_R_W;
            ltf_pkg::ST_R_W:
                if (div_done) state_next = last_idx ? ltf_pkg::ST_MEAN : ltf_pkg::ST_RD;
            ltf_pkg::ST_MEAN:    state_next = ltf_pkg::ST_MEAN_W;
            ltf_pkg::ST_MEAN_W:
                if (div_done) state_next = ax_reg ? ltf_pkg::ST_DONE : ltf_pkg::ST_CHK;
            ltf_pkg::ST_DONE:    if (out_free) state_next = ltf_pkg::ST_IDLE;
            default:             state_next = ltf_pkg::ST_IDLE;
        endcase
    end

    // datapath controls and register updates
    always_comb
    begin
        cnt_next      = cnt_reg;
        s_sum_next    = s_sum_reg;
        r_sum_next    = r_sum_reg;
        ss_sum_next   = ss_sum_reg;
        sr_sum_next   = sr_sum_reg;
        ax_next       = ax_reg;
        fail_next     = fail_reg || fail_now;
        tneg_next     = tneg_reg;
        acc_next      = acc_reg;
        den_next      = den_reg;
        num_next      = num_reg;
        slope_next    = slope_reg;
        icpt_next     = icpt_reg;
        idx_next      = idx_reg;
        r_next        = r_reg;
        total_next    = total_reg;
        worst_next    = worst_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mean_next     = mean_reg;
        max_next      = max_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mul_a         = '0;
        mul_b         = '0;
        div_req       = '0;

        // first-order sums are plain adds on the accepted transaction that is stored
        if (ram_we)
        begin
            cnt_next      = cnt_reg + 1'b1;
            s_sum_next[0] = s_sum_reg[0] + ltf_pkg::S_W'(s_tdata[ltf_pkg::SCR_W-1:0]);
            s_sum_next[1] = s_sum_reg[1]
                            + ltf_pkg::S_W'(s_tdata[2*ltf_pkg::SCR_W-1 -: ltf_pkg::SCR_W]);
            r_sum_next[0] = r_sum_reg[0]
                            + ltf_pkg::R_W'(s_tdata[2*ltf_pkg::SCR_W+ltf_pkg::RAW_W-1
                                                    -: ltf_pkg::RAW_W]);
            r_sum_next[1] = r_sum_reg[1]
                            + ltf_pkg::R_W'(s_tdata[ltf_pkg::ENTRY_W-1 -: ltf_pkg::RAW_W]);
        end

        unique case (state_reg)
            // products are issued one state and summed the next
            ltf_pkg::ST_LD0:
            begin
                mul_a = ltf_pkg::MA_W'(sx_reg);
                mul_b = ltf_pkg::MB_W'(sx_reg);
            end
            ltf_pkg::ST_LD1:
            begin
                mul_a = ltf_pkg::MA_W'(sy_reg);
                mul_b = ltf_pkg::MB_W'(sy_reg);
                if (keep_reg) ss_sum_next[0] = ss_sum_reg[0] + ltf_pkg::SS_W'(p_reg);
            end
            ltf_pkg::ST_LD2:
            begin
                mul_a = ltf_pkg::MA_W'(rx_reg);
                mul_b = ltf_pkg::MB_W'(sx_reg);
                if (keep_reg) ss_sum_next[1] = ss_sum_reg[1] + ltf_pkg::SS_W'(p_reg);
            end
            ltf_pkg::ST_LD3:
            begin
                mul_a = ltf_pkg::MA_W'(ry_reg);
                mul_b = ltf_pkg::MB_W'(sy_reg);
                if (keep_reg) sr_sum_next[0] = sr_sum_reg[0] + ltf_pkg::SR_W'(p_reg);
            end
            ltf_pkg::ST_LD4:
            begin
                if (keep_reg) sr_sum_next[1] = sr_sum_reg[1] + ltf_pkg::SR_W'(p_reg);
            end
            // den = n*SS - S*S, num = n*SR - S*R
            ltf_pkg::ST_CHK:
            begin
                mul_a = ltf_pkg::MA_W'(ss_sel);
                mul_b = ltf_pkg::MB_W'(cnt_reg);
            end
            ltf_pkg::ST_M1:
            begin
                mul_a    = ltf_pkg::MA_W'(s_sel);
                mul_b    = ltf_pkg::MB_W'(s_sel);
                acc_next = p_reg;
            end
            ltf_pkg::ST_M2:
            begin
                mul_a    = ltf_pkg::MA_W'(sr_sel);
                mul_b    = ltf_pkg::MB_W'(cnt_reg);
                den_next = ltf_pkg::DEN_W'(acc_reg - p_reg);
            end
            ltf_pkg::ST_M3:
            begin
                mul_a    = ltf_pkg::MA_W'(r_sel);
                mul_b    = ltf_pkg::MB_W'(s_sel);
                acc_next = p_reg;
            end
            ltf_pkg::ST_M4:
            begin
                num_next = ltf_pkg::NUM_W'(acc_reg - p_reg);
            end
            ltf_pkg::ST_SLOPE:
            begin
                tneg_next        = t_w < 0;
                div_req.start    = 1'b1;
                div_req.dividend = ltf_pkg::DIVD_W'(t_mag);
                div_req.divisor  = ltf_pkg::DIVR_W'(den_reg);
            end
            ltf_pkg::ST_SLOPE_W:
            begin
                if (div_done)
                begin
                    slope_next = tneg_reg ? -$signed(slope_mag) : $signed(slope_mag);
                end
            end
            // intercept = (R*4096 - slope*S) / n
            ltf_pkg::ST_IC0:
            begin
                mul_a = ltf_pkg::MA_W'(slope_reg);
                mul_b = ltf_pkg::MB_W'(s_sel);
            end
            ltf_pkg::ST_IC1:
            begin
                tneg_next        = t_w < 0;
                div_req.start    = 1'b1;
                div_req.dividend = ltf_pkg::DIVD_W'(t_mag);
                div_req.divisor  = ltf_pkg::DIVR_W'(cnt_reg);
            end
            ltf_pkg::ST_IC_W:
            begin
                if (div_done)
                begin
                    icpt_next = tneg_reg ? -$signed(ltf_pkg::WIDE_W'(div_q))
                                         : $signed(ltf_pkg::WIDE_W'(div_q));
                end
            end
            // endpoints at screen 0 and at size minus one
            ltf_pkg::ST_E0:
            begin
                mul_a           = ltf_pkg::MA_W'(slope_reg);
                mul_b           = ltf_pkg::MB_W'(span);
                lo_next[ax_reg] = sat_ep(t_w < 0, ltf_pkg::DIVD_W'(ep_q));
            end
            ltf_pkg::ST_E1:
            begin
                hi_next[ax_reg] = sat_ep(t_w < 0, ltf_pkg::DIVD_W'(ep_q));
                idx_next        = '0;
                total_next      = '0;
                worst_next      = '0;
            end
            // residual walk over the stored samples
            ltf_pkg::ST_RM:
            begin
                mul_a  = ltf_pkg::MA_W'(slope_reg);
                mul_b  = ltf_pkg::MB_W'(st_s);
                r_next = st_r;
            end
            ltf_pkg::ST_RDIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = ltf_pkg::DIVD_W'({t_mag, 4'b0});
                div_req.divisor  = ltf_pkg::DIVR_W'(aslope);
            end
            ltf_pkg::ST_R_W:
            begin
                if (div_done)
                begin
                    total_next = total_reg + ltf_pkg::TOT_W'(res);
                    if (res > worst_reg) worst_next = res;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ltf_pkg::ST_MEAN:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = ltf_pkg::DIVD_W'(total_reg);
                div_req.divisor  = ltf_pkg::DIVR_W'(cnt_reg);
            end
            ltf_pkg::ST_MEAN_W:
            begin
                if (div_done)
                begin
                    mean_next[ax_reg] = sat_err(div_q);
                    max_next[ax_reg]  = sat_err(ltf_pkg::DIVD_W'(worst_reg));
                    ax_next           = 1'b1;
                end
            end
            // load the result register and open a new batch
            ltf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = fail_reg;
                    m_tdata_next  = fail_reg ? '0
                                   : ltf_pkg::M_TDATA_W'({max_reg[1], mean_reg[1],
                                                           max_reg[0], mean_reg[0],
                                                           hi_reg[1], lo_reg[1],
                                                           hi_reg[0], lo_reg[0]});
                    cnt_next      = '0;
                    s_sum_next    = '{default: '0};
                    r_sum_next    = '{default: '0};
                    ss_sum_next   = '{default: '0};
                    sr_sum_next   = '{default: '0};
                    ax_next       = 1'b0;
                    fail_next     = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ltf_pkg::ST_IDLE;
            pw_reg       <= ltf_pkg::PANEL_WIDTH_RST;
            ph_reg       <= ltf_pkg::PANEL_HEIGHT_RST;
            cnt_reg      <= '0;
            s_sum_reg    <= '{default: '0};
            r_sum_reg    <= '{default: '0};
            ss_sum_reg   <= '{default: '0};
            sr_sum_reg   <= '{default: '0};
            ax_reg       <= 1'b0;
            fail_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            s_sum_reg    <= s_sum_next;
            r_sum_reg    <= r_sum_next;
            ss_sum_reg   <= ss_sum_next;
            sr_sum_reg   <= sr_sum_next;
            ax_reg       <= ax_next;
            fail_reg     <= fail_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    ltf_pkg::CFG_PANEL_WIDTH:  pw_reg <= cfg_wdata;
                    ltf_pkg::CFG_PANEL_HEIGHT: ph_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            sx_reg   <= s_tdata[ltf_pkg::SCR_W-1:0];
            sy_reg   <= s_tdata[2*ltf_pkg::SCR_W-1 -: ltf_pkg::SCR_W];
            rx_reg   <= s_tdata[2*ltf_pkg::SCR_W+ltf_pkg::RAW_W-1 -: ltf_pkg::RAW_W];
            ry_reg   <= s_tdata[ltf_pkg::ENTRY_W-1 -: ltf_pkg::RAW_W];
            last_reg <= s_tlast;
            keep_reg <= ram_we;
        end
        tneg_reg    <= tneg_next;
        acc_reg     <= acc_next;
        den_reg     <= den_next;
        num_reg     <= num_next;
        slope_reg   <= slope_next;
        icpt_reg    <= icpt_next;
        idx_reg     <= idx_next;
        r_reg       <= r_next;
        total_reg   <= total_next;
        worst_reg   <= worst_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mean_reg    <= mean_next;
        max_reg     <= max_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    ltf_ram #(
        .WIDTH (ltf_pkg::ENTRY_W),
        .DEPTH (ltf_pkg::MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[ltf_pkg::ADDR_W-1:0]),
        .wdata (s_tdata[ltf_pkg::ENTRY_W-1:0]),
        .raddr (idx_reg[ltf_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    ltf_mul u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (p_reg)
    );

    ltf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done_reg (div_done),
        .quo_reg  (div_q)
    );

endmodule

@@ rtl/ltf_chk.sv @@
// ltf_chk: port-level checks for touch_calibration_line_fit, bound to the top level
// depends on ltf_pkg

module ltf_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ltf_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                              m_tuser
);

    // every sample occupies the loader, so s_tready drops after each accepted sample
    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    // a failed fit carries no numbers
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("failed fit with nonzero result fields");

    // the mean residual never exceeds the largest one
    a_mean_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[99:84] >= m_tdata[83:68])
                               && (m_tdata[131:116] >= m_tdata[115:100]))
        else $error("mean residual above maximum residual");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind touch_calibration_line_fit ltf_chk u_ltf_chk (.*);

@@ tb/touch_calibration_line_fit_tb.sv @@
// touch_calibration_line_fit_tb: self-checking testbench for the touch calibration line fit
// depends on ltf_pkg and the touch_calibration_line_fit rtl; predicts every fit result
// from its own model of the least squares arithmetic and checks it field by field

`timescale 1ns / 1ps

// holds the predicted fit results and compares them with what the block sends out
class fit_scoreboard;
    localparam int NS = ltf_pkg::MAX_SAMPLES;

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    int unsigned count;
    logic [9:0]  scr [2][NS];
    logic [15:0] raw [2][NS];
    logic [ltf_pkg::M_TDATA_W:0] pending_fits[$];
    int errors;
    int fits_seen;
    int fails_seen;

    function new();
        width_reg = 13'd320;
        height_reg = 13'd480;
        count = 0;
        errors = 0;
        fits_seen = 0;
        fails_seen = 0;
    endfunction

    function longint rdiv(longint a, longint d);
        longint q;
        q = ((a < 0 ? -a : a) + d / 2) / d;
        return a < 0 ? -q : q;
    endfunction

    function logic [16:0] sat17(longint v);
        if (v > 65535) v = 65535;
        if (v < -65536) v = -65536;
        return v[16:0];
    endfunction

    // per axis fit: returns 0 when the fit fails
    function bit fit_axis(int a, logic [12:0] size, output logic [16:0] lo,
                          output logic [16:0] hi, output logic [15:0] mean,
                          output logic [15:0] worst);
        longint n, s, r, ss, sr, den, num, slope, icpt, span, d, aslope, res, tot, mx, m;
        n = count;
        s = 0; r = 0; ss = 0; sr = 0; tot = 0; mx = 0;
        lo = '0; hi = '0; mean = '0; worst = '0;
        if (n < 2) return 0;
        for (int i = 0; i < count; i++)
        begin
            s += scr[a][i];
            r += raw[a][i];
            ss += longint'(scr[a][i]) * scr[a][i];
            sr += longint'(scr[a][i]) * raw[a][i];
        end
        den = n * ss - s * s;
        num = n * sr - s * r;
        if (den <= 0) return 0;
        slope = rdiv(num * 4096, den);
        if (slope > (64'sd1 <<< 36)) slope = 64'sd1 <<< 36;
        if (slope < -(64'sd1 <<< 36)) slope = -(64'sd1 <<< 36);
        if (slope == 0) return 0;
        icpt = rdiv(r * 4096 - slope * s, n);
        span = (size == 0) ? 0 : size - 1;
        lo = sat17(rdiv(icpt, 4096));
        hi = sat17(rdiv(icpt + slope * span, 4096));
        aslope = slope < 0 ? -slope : slope;
        for (int i = 0; i < count; i++)
        begin
            d = longint'(raw[a][i]) * 4096 - icpt - slope * scr[a][i];
            if (d < 0) d = -d;
            res = (16 * d + aslope / 2) / aslope;
            if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
            tot += res;
            if (res > mx) mx = res;
        end
        m = (tot + n / 2) / n;
        mean = m > 65535 ? 16'hFFFF : m[15:0];
        worst = mx > 65535 ? 16'hFFFF : mx[15:0];
        return 1;
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] val);
        if (idx == ltf_pkg::CFG_PANEL_WIDTH) width_reg = val;
        else if (idx == ltf_pkg::CFG_PANEL_HEIGHT) height_reg = val;
    endfunction

    // note one accepted sample transaction
    function void note_sample(logic [9:0] sx, logic [9:0] sy, logic [15:0] rx,
                              logic [15:0] ry, logic last);
        logic [16:0] ep [4];
        logic [15:0] er [4];
        logic [ltf_pkg::M_TDATA_W:0] word;
        bit ok;
        if (count < NS)
        begin
            scr[0][count] = sx; scr[1][count] = sy;
            raw[0][count] = rx; raw[1][count] = ry;
            count++;
        end
        if (!last) return;
        ok = fit_axis(0, width_reg, ep[0], ep[1], er[0], er[1]);
        if (ok) ok = fit_axis(1, height_reg, ep[2], ep[3], er[2], er[3]);
        word = '0;
        if (ok)
            word[131:0] = {er[3], er[2], er[1], er[0], ep[3], ep[2], ep[1], ep[0]};
        word[ltf_pkg::M_TDATA_W] = !ok;
        pending_fits.push_back(word);
        count = 0;
    endfunction

    // check one result transaction against the oldest prediction
    function void check_fit(logic [ltf_pkg::M_TDATA_W-1:0] data, logic failed);
        logic [ltf_pkg::M_TDATA_W:0] exp_w, got;
        got = {failed, data};
        if (pending_fits.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp_w = pending_fits.pop_front();
        fits_seen++;
        if (failed) fails_seen++;
        if (exp_w !== got)
            $display("%0t: result mismatch expected %h actual %h", $time, exp_w, got);
        if (exp_w !== got) errors++;
    endfunction
endclass

module touch_calibration_line_fit_tb;
    import ltf_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    fit_scoreboard fits = new();
    bit sender_quiet = 0;     // no idling in the closing phase
    bit hold_receiver = 0;    // long stall to back the block up
    int samples_sent = 0;

    always #2 clk = ~clk;

    touch_calibration_line_fit DUT (.*);

    // receiver: random stall bursts, plus one long hold-off
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready) fits.check_fit(m_tdata, m_tuser);
            if (hold_receiver || (!sender_quiet && stall > 0))
            begin
                m_tready <= 1'b0;
                if (stall > 0) stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!sender_quiet && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 18);
            end
        end
    end

    // one sample transaction; idles before it at random
    task automatic send_sample(logic [9:0] sx, logic [9:0] sy, logic [15:0] rx,
                               logic [15:0] ry, logic last);
        if (!sender_quiet && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'({ry, rx, sy, sx});
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        fits.note_sample(sx, sy, rx, ry, last);
        samples_sent++;
    endtask

    // wait until all fits are out, then let the block settle before a register write
    task automatic drain_and_write(logic [1:0] idx, logic [12:0] val);
        s_tvalid <= 1'b0;
        while (fits.pending_fits.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        fits.write_reg(idx, val);
    endtask

    // a batch of n samples on a noisy line of random slope, ending with last
    task automatic send_batch(int n);
        int gx, gy, ox, oy, nz;
        logic [9:0] sx, sy;
        gx = $urandom_range(0, 255) - 128;
        gy = $urandom_range(0, 255) - 128;
        ox = $urandom_range(0, 65535);
        oy = $urandom_range(0, 65535);
        nz = $urandom_range(0, 3) == 0 ? 4096 : 64;
        for (int i = 0; i < n; i++)
        begin
            sx = $urandom_range(0, 1023);
            sy = $urandom_range(0, 1023);
            send_sample(sx, sy,
                        16'(ox + gx * sx / 8 + $urandom_range(0, nz)),
                        16'(oy + gy * sy / 8 + $urandom_range(0, nz)), i == n - 1);
        end
    endtask

    initial
    begin
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: too few samples, singular fit, exact lines, extreme fields
        send_sample(10'd5, 10'd5, 16'd100, 16'd100, 1'b1);
        send_sample(10'd7, 10'd8, 16'd10, 16'd20, 1'b0);
        send_sample(10'd7, 10'd8, 16'd30, 16'd40, 1'b1);
        send_sample(10'd0, 10'd0, 16'd0, 16'd0, 1'b0);
        send_sample(10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF, 1'b1);
        send_sample(10'd0, 10'd1023, 16'hFFFF, 16'd0, 1'b0);
        send_sample(10'd1023, 10'd0, 16'd0, 16'hFFFF, 1'b1);
        // flat line gives a zero slope
        send_sample(10'd0, 10'd0, 16'd500, 16'd0, 1'b0);
        send_sample(10'd900, 10'd900, 16'd500, 16'd9000, 1'b1);
        // overfull batch: extra samples are dropped, last still fits
        for (int i = 0; i < 20; i++)
            send_sample(10'(i * 50), 10'(1000 - i * 40), 16'(i * 3000),
                        16'(i * 1111 + 7), i == 19);

        // panel size extremes, including zero
        drain_and_write(CFG_PANEL_WIDTH, 13'd0);
        drain_and_write(CFG_PANEL_HEIGHT, 13'd4096);
        send_batch(5);
        send_batch(16);
        drain_and_write(CFG_PANEL_WIDTH, 13'h1FFF);
        drain_and_write(CFG_PANEL_HEIGHT, 13'd1);
        send_batch(3);
        drain_and_write(2'd3, 13'h1234);
        drain_and_write(CFG_PANEL_WIDTH, 13'd1);
        drain_and_write(CFG_PANEL_HEIGHT, 13'd0);
        send_batch(17);

        // long receiver stall while batches keep coming
        hold_receiver = 1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_receiver = 0;
            end
            repeat (4) send_batch($urandom_range(2, 4));
        join

        for (int phase = 0; phase < 4; phase++)
        begin
            drain_and_write(CFG_PANEL_WIDTH, 13'($urandom_range(1, 4096)));
            drain_and_write(CFG_PANEL_HEIGHT, 13'($urandom_range(1, 4096)));
            if (phase == 3) sender_quiet = 1;
            while (samples_sent < 500 * (phase + 1) - 50)
            begin
                n = $urandom_range(0, 9);
                if (n == 0) send_sample(10'($urandom), 10'($urandom), 16'($urandom),
                                        16'($urandom), $urandom_range(0, 1));
                else if (n == 1) send_batch($urandom_range(1, 20));
                else send_batch($urandom_range(2, 8));
            end
        end
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;

        while (fits.pending_fits.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d samples and %0d fits (%0d failed fits), panel sizes 0 to 8191",
                 samples_sent, fits.fits_seen, fits.fails_seen);
        if (fits.errors == 0 && fits.pending_fits.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
